### src/wbps_pkg.sv
package wbps_pkg;

    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int LEN_W     = 5;
    localparam int PAT_W     = 2 * CFG_W;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 2'd2;

    localparam logic [BYTE_W-1:0] WILDCARD_BYTE = 8'h3F;

    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic [LEN_W-1:0] len;
    } t_cfg;

endpackage

### src/wbps_in_if.sv
interface wbps_in_if;
    import wbps_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic [ADDR_W-1:0] byte_address;
    logic              region_first;

    modport source (output valid, data_byte, byte_address, region_first, input ready);
    modport sink   (input valid, data_byte, byte_address, region_first, output ready);
endinterface

### src/wbps_out_if.sv
interface wbps_out_if;
    import wbps_pkg::*;

    logic              valid;
    logic              ready;
    logic              match_found;
    logic [ADDR_W-1:0] match_address;

    modport source (output valid, match_found, match_address, input ready);
    modport sink   (input valid, match_found, match_address, output ready);
endinterface

### src/wbps_cfg.sv
module wbps_cfg #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wbps_pkg::CFG_W-1:0]     i_cfg_wdata,
    output wbps_pkg::t_cfg                 o_cfg
);
    import wbps_pkg::*;

    logic [CFG_W-1:0] r_pat_low;
    logic [CFG_W-1:0] r_pat_high;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;

    // hold the length already clamped to the usable range
    always_comb begin
        n_len = i_cfg_wdata[LEN_W-1:0];
        if (n_len == '0) begin
            n_len = LEN_W'(1);
        end else if (n_len > LEN_W'(PATTERN_MAX)) begin
            n_len = LEN_W'(PATTERN_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_len      <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN_LOW:  r_pat_low  <= i_cfg_wdata;
                CFG_PATTERN_HIGH: r_pat_high <= i_cfg_wdata;
                CFG_PATTERN_LEN:  r_len      <= n_len;
                default: ;
            endcase
        end
    end

    assign o_cfg.pattern = {r_pat_high, r_pat_low};
    assign o_cfg.len     = r_len;

endmodule

### src/wbps_match.sv
module wbps_match #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wbps_pkg::t_cfg              i_cfg,
    input  logic                        i_step,
    input  logic [wbps_pkg::BYTE_W-1:0] i_byte,
    input  logic [wbps_pkg::ADDR_W-1:0] i_addr,
    input  logic                        i_first,
    output logic                        o_found,
    output logic [wbps_pkg::ADDR_W-1:0] o_start
);
    import wbps_pkg::*;

    localparam int WIN_D  = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam int WIN_IW = (WIN_D > 1) ? $clog2(WIN_D) : 1;

    logic [BYTE_W-1:0] r_window [WIN_D];
    logic [LEN_W-1:0]  r_fill;
    logic [LEN_W-1:0]  n_fill;
    logic [LEN_W-1:0]  fill_base;
    logic [LEN_W-1:0]  fill_inc;
    logic [LEN_W-1:0]  back;
    logic [BYTE_W-1:0] cand;
    logic [BYTE_W-1:0] pbyte;
    logic              hit;
    logic              found;

    // pattern byte j lines up with the byte (len-1-j) places back
    always_comb begin
        hit   = 1'b1;
        back  = '0;
        cand  = '0;
        pbyte = '0;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if (LEN_W'(j) < i_cfg.len) begin
                back  = i_cfg.len - LEN_W'(1) - LEN_W'(j);
                pbyte = i_cfg.pattern[j*BYTE_W +: BYTE_W];
                cand  = (back == '0) ? i_byte : r_window[WIN_IW'(back - LEN_W'(1))];
                if (pbyte != WILDCARD_BYTE && pbyte != cand) begin
                    hit = 1'b0;
                end
            end
        end
    end

    // restart the run on a region start, saturate at the pattern maximum
    assign fill_base = i_first ? '0 : r_fill;
    assign fill_inc  = (fill_base < LEN_W'(PATTERN_MAX)) ? fill_base + LEN_W'(1) : fill_base;
    assign found     = (fill_inc >= i_cfg.len) && hit;
    assign n_fill    = found ? '0 : fill_inc;

    assign o_found = found;
    assign o_start = found ?
        i_addr - {{(ADDR_W-LEN_W){1'b0}}, i_cfg.len - LEN_W'(1)} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_step) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_window[0] <= i_byte;
            for (int k = 1; k < WIN_D; k++) begin
                r_window[k] <= r_window[k-1];
            end
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LEN_W'(PATTERN_MAX))
        else $error("fill count beyond pattern maximum");

    a_fill_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && found) |=> (r_fill == '0))
        else $error("fill count not cleared after a match");

    a_match_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        found |-> (fill_inc >= i_cfg.len))
        else $error("match reported on a short window");

    a_region_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_first && found) |-> (i_cfg.len == LEN_W'(1)))
        else $error("match spans a region start");
`endif

endmodule

### src/wildcard_byte_pattern_scan.sv
// Wildcard byte pattern scanner. Bytes arrive on the input channel with their
// address and a first-of-region flag; each accepted byte yields exactly one
// result giving match_found and the start address of a match that ends at
// that byte (zero when there is none). A pattern byte of 0x3F matches any
// byte, so a literal 0x3F cannot be demanded. After a match the run restarts,
// so matches never overlap, and no match spans a region start. Only the low
// LEN_W bits of a pattern_len write count: 0 there acts as 1 and a value
// above PATTERN_MAX acts as PATTERN_MAX. The block takes one byte per clock:
// a byte is held in the input register while the window compare runs into
// the result register, from which its result is offered to the sink. A
// result held back by the sink stalls the input once both registers are
// full. Write configuration only while idle.
module wildcard_byte_pattern_scan #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wbps_pkg::CFG_W-1:0]     i_cfg_wdata,
    wbps_in_if.sink                        i_in,
    wbps_out_if.source                     o_out
);
    import wbps_pkg::*;

    t_cfg              cfg;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic [ADDR_W-1:0] r_in_addr;
    logic              r_in_first;
    logic              r_out_valid;
    logic              r_out_found;
    logic [ADDR_W-1:0] r_out_addr;
    logic              out_load;
    logic              step;
    logic              found;
    logic [ADDR_W-1:0] start;

    assign out_load   = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && out_load;
    assign i_in.ready = !r_in_valid || out_load;

    wbps_cfg #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    wbps_match #(.PATTERN_MAX(PATTERN_MAX)) u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_addr  (r_in_addr),
        .i_first (r_in_first),
        .o_found (found),
        .o_start (start)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte  <= i_in.data_byte;
            r_in_addr  <= i_in.byte_address;
            r_in_first <= i_in.region_first;
        end
    end

    // advance the result register whenever the sink takes or it is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_found <= found;
            r_out_addr  <= start;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.match_found   = r_out_found;
    assign o_out.match_address = r_out_addr;

endmodule
